### sv/pen_pkg.sv
// Shared types, constants and character functions of the percent-escape normalizer.
package pen_pkg;

	localparam int MAX_OUT = 5;
	localparam int CNT_W = 3;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] CH_PCT = 8'h25;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] bytes;
		logic [CNT_W-1:0]        n;
		logic                    last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_flags_t;

	function automatic logic is_unreserved(input logic [7:0] b);
		logic r;
		case (b) inside
			[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], 8'h2D, 8'h2E, 8'h5F, 8'h7E: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_delimiter(input logic [7:0] b);
		logic r;
		case (b) inside
			8'h3A, 8'h2F, 8'h3F, 8'h23, 8'h5B, 8'h5D, 8'h40, 8'h21, 8'h24,
			8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// bit 4 set: not a hex digit
	function automatic logic [4:0] nibble_of(input logic [7:0] b);
		logic [4:0] r;
		case (b) inside
			[8'h30:8'h39]: r = {1'b0, b[3:0]};
			[8'h41:8'h46], [8'h61:8'h66]: r = {1'b0, b[3:0] + 4'd9};
			default: r = 5'b10000;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] r;
		if (v < 4'd10) begin
			r = CH_ZERO + {4'b0000, v};
		end else begin
			r = CH_UPPER_A + {4'b0000, v - 4'd10};
		end
		return r;
	endfunction

endpackage

### sv/pen_front.sv
// Front end: escape hold state and classification of each input byte into a byte group.
module pen_front
	import pen_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t item,
	input  logic     lowercase,
	output logic     push,
	output cmd_t     cmd
);

	localparam logic [1:0] HELD_NONE  = 2'd0;
	localparam logic [1:0] HELD_PCT   = 2'd1;
	localparam logic [1:0] HELD_DIGIT = 2'd2;

	logic [1:0] held_count_q;
	logic [7:0] held_digit_q;
	logic [1:0] held_next;
	logic [4:0] held_nib;

	function automatic cmd_t put(input cmd_t c, input logic [7:0] b);
		cmd_t r;
		r = c;
		r.bytes[c.n] = b;
		r.n = c.n + CNT_W'(1);
		return r;
	endfunction

	function automatic logic [7:0] lit(input logic [7:0] b, input logic lc);
		logic [7:0] r;
		r = b;
		if (lc && b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
			r = b + CASE_OFFSET;
		end
		return r;
	endfunction

	function automatic cmd_t put_escape(input cmd_t c, input logic [7:0] v);
		cmd_t r;
		r = put(c, CH_PCT);
		r = put(r, hex_digit(v[7:4]));
		r = put(r, hex_digit(v[3:0]));
		return r;
	endfunction

	assign held_nib = nibble_of(held_digit_q);

	always_comb begin
		logic [7:0] b;
		logic       last;
		logic [4:0] nb;
		logic [4:0] hi;
		logic [7:0] v;
		logic       fresh;
		cmd_t       c;
		b = item.in_byte;
		last = item.in_last;
		nb = nibble_of(b);
		hi = held_nib;
		v = {hi[3:0], nb[3:0]};
		fresh = 1'b0;
		held_next = HELD_NONE;
		c = '0;
		c.last = last;
		unique case (held_count_q)
			HELD_PCT: begin
				if (!nb[4] && !last) begin
					held_next = HELD_DIGIT;
				end else if (!nb[4]) begin
					c = put(c, CH_PCT);
					c = put(c, lit(b, lowercase));
				end else begin
					c = put(c, CH_PCT);
					fresh = 1'b1;
				end
			end
			HELD_DIGIT: begin
				if (!nb[4] && !hi[4]) begin
					if (is_unreserved(v)) begin
						c = put(c, lit(v, lowercase));
					end else begin
						c = put_escape(c, v);
					end
				end else begin
					c = put(c, CH_PCT);
					c = put(c, lit(held_digit_q, lowercase));
					fresh = 1'b1;
				end
			end
			default: begin
				fresh = 1'b1;
			end
		endcase
		if (fresh) begin
			if (b == CH_PCT) begin
				if (last) begin
					c = put(c, CH_PCT);
				end else begin
					held_next = HELD_PCT;
				end
			end else if (is_delimiter(b) || is_unreserved(b)) begin
				c = put(c, lit(b, lowercase));
			end else begin
				c = put_escape(c, b);
			end
		end
		if (last) begin
			held_next = HELD_NONE;
		end
		cmd = c;
	end

	assign push = accept && (cmd.n != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= HELD_NONE;
			held_digit_q <= 8'h00;
		end else if (accept) begin
			held_count_q <= held_next;
			if (held_next == HELD_DIGIT) begin
				held_digit_q <= item.in_byte;
			end
		end
	end

`ifndef ASSERT_OFF
	a_digit_is_hex: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q == HELD_DIGIT |-> !held_nib[4])
		else $error("held digit is not hex");
	a_group_size: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cmd.n <= CNT_W'(MAX_OUT))
		else $error("byte group too large");
`endif

endmodule

### sv/pen_queue.sv
// Short queue of byte groups between front and back ends.
module pen_queue
	import pen_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  cmd_t     wr_data,
	input  logic     pop,
	output cmd_t     rd_data,
	output q_flags_t flags
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign flags.full = (count_q == CW'(DEPTH));
	assign flags.nonempty = (count_q != '0);
	assign do_push = push && !flags.full;
	assign do_pop = pop && flags.nonempty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count overflow");
	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count did not advance on push");
`endif

endmodule

### sv/pen_back.sv
// Back end: serializes byte groups into the registered output channel.
module pen_back
	import pen_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      q_data,
	input  q_flags_t  q_flags,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	cmd_t             cur_q;
	logic             cur_valid_q;
	logic [CNT_W-1:0] idx_q;
	logic             out_valid_q;
	out_item_t        out_q;
	logic             can_load;
	logic             issue;
	logic             cur_done;

	assign can_load = !out_valid_q || !out_stall;
	assign issue = cur_valid_q && can_load;
	assign cur_done = issue && (idx_q == cur_q.n - CNT_W'(1));
	assign pop = q_flags.nonempty && (!cur_valid_q || cur_done);
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (can_load) begin
				out_valid_q <= issue;
			end
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q <= '0;
			end else if (cur_done) begin
				cur_valid_q <= 1'b0;
			end else if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_data;
		end
		if (issue) begin
			out_q.out_byte <= cur_q.bytes[idx_q];
			out_q.out_last <= cur_q.last && cur_done;
		end
	end

`ifndef ASSERT_OFF
	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (cur_q.n != '0) && (idx_q < cur_q.n))
		else $error("serializer index outside byte group");
`endif

endmodule

### sv/percent_escape_normalizer_unit.sv
// Top level of the percent-escape normalizer: config register, front end, queue, back end.
// Output path: queue, back-end current group register, then the registered output.
// Throughput: one input byte per cycle while in_stall is low; an item's bytes leave one by one,
// a held '%' or hex digit yields none; the queue absorbs expansion up to its depth.
// Reset: arst_n clears hold state, queue, serializer, output valid and lowercase_q.
module percent_escape_normalizer_unit
	import pen_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);

	logic     lowercase_q;
	logic     accept;
	logic     push;
	cmd_t     push_cmd;
	logic     pop;
	cmd_t     q_data;
	q_flags_t q_flags;

	assign cfg_ready = 1'b1;
	assign in_stall = q_flags.full;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowercase_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			lowercase_q <= cfg_data;
		end
	end

	pen_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (in_item),
		.lowercase (lowercase_q),
		.push      (push),
		.cmd       (push_cmd)
	);

	pen_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_cmd),
		.pop     (pop),
		.rd_data (q_data),
		.flags   (q_flags)
	);

	pen_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (q_data),
		.q_flags   (q_flags),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule
